>>> rtl/rapq_pkg.sv
// Package with shared types, codes and constants of the request admission queue.
package rapq_pkg;

  localparam int unsigned PoolSlotsDef      = 8;
  localparam int unsigned PduLimitDef       = 253;
  localparam int unsigned DefaultTimeoutDef = 1000;
  localparam int unsigned PoisonTimeoutDef  = 60000;

  // Opcodes of an input item.
  localparam logic [1:0] OP_FRAME  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_POISON = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result kinds.
  localparam logic [3:0] K_ACCEPT     = 4'd0;
  localparam logic [3:0] K_IGNORED    = 4'd1;
  localparam logic [3:0] K_REJ_EXC    = 4'd2;
  localparam logic [3:0] K_REJ_SIL    = 4'd3;
  localparam logic [3:0] K_FRAME_ERR  = 4'd4;
  localparam logic [3:0] K_DISPATCH   = 4'd5;
  localparam logic [3:0] K_TMO_EXC    = 4'd6;
  localparam logic [3:0] K_TMO_SIL    = 4'd7;
  localparam logic [3:0] K_CANCEL_EXC = 4'd8;
  localparam logic [3:0] K_CANCEL_SIL = 4'd9;

  // Exception codes.
  localparam logic [2:0] EXC_NONE    = 3'd0;
  localparam logic [2:0] EXC_ILLEGAL = 3'd3;
  localparam logic [2:0] EXC_FAIL    = 3'd4;

  // Function codes with special handling.
  localparam logic [7:0] FN_READ_HOLDING = 8'd3;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FN_WRITE_MULTI  = 8'd16;

  // Register indexes.
  localparam logic [2:0] REG_OWN_UNIT = 3'd0;
  localparam logic [2:0] REG_QLIMIT   = 3'd1;
  localparam logic [2:0] REG_TMO_RH   = 3'd2;
  localparam logic [2:0] REG_TMO_WS   = 3'd3;
  localparam logic [2:0] REG_TMO_WM   = 3'd4;
  localparam logic [2:0] REG_TMO_OTH  = 3'd5;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch;    // capture the input item
    logic admit;    // run frame or poison admission, emit one result
    logic pop;      // dequeue head and emit a result
    logic final_r;  // the emitted result is the last one
    logic drain;    // popped entries are cancelled behind a poison dispatch
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic no_op;         // unused opcode, no results
    logic empty_now;     // queue empty
    logic expired;       // head entry deadline reached
    logic head_poison;   // head entry is poison
    logic single_left;   // one entry queued
  } sts_t;

endpackage

>>> rtl/rapq_ctrl.sv
// Controller state machine that sequences admission, expiry, dispatch and drain.
module rapq_ctrl
  import rapq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   drain_q, drain_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    drain_d     = drain_q;
    cmd_o       = '0;
    cmd_o.drain = drain_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.is_tick) begin
          drain_d = 1'b0;
          state_d = ST_CHECK;
        end else if (sts_i.no_op) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.admit   = 1'b1;
          cmd_o.final_r = 1'b1;
          state_d       = ST_DONE;
        end
      end
      ST_CHECK: begin
        // Expired heads go first, then one dispatch; a poison head with entries behind it starts a drain.
        if (sts_i.empty_now) begin
          state_d = ST_DONE;
        end else if (sts_i.expired) begin
          cmd_o.pop     = 1'b1;
          cmd_o.final_r = sts_i.single_left;
        end else begin
          cmd_o.pop     = 1'b1;
          cmd_o.final_r = sts_i.single_left || !sts_i.head_poison;
          if (sts_i.head_poison && !sts_i.single_left) begin
            drain_d = 1'b1;
            state_d = ST_DRAIN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DRAIN: begin
        cmd_o.pop     = 1'b1;
        cmd_o.final_r = sts_i.single_left;
        if (sts_i.single_left) state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
    end
  end

endmodule

>>> rtl/rapq_dp.sv
// Datapath with slot pool, linked deque, deadline checks and the result register.
module rapq_dp
  import rapq_pkg::*;
#(
  parameter int unsigned PduLimit       = PduLimitDef,
  parameter int unsigned DefaultTimeout = DefaultTimeoutDef,
  parameter int unsigned PoisonTimeout  = PoisonTimeoutDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  opcode_i,
  input  logic        frame_ok_i,
  input  logic [7:0]  frame_unit_i,
  input  logic [7:0]  frame_function_i,
  input  logic [7:0]  payload_length_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  own_unit_i,
  input  logic [3:0]  queue_limit_i,
  input  logic [31:0] tmo_rh_i,
  input  logic [31:0] tmo_ws_i,
  input  logic [31:0] tmo_wm_i,
  input  logic [31:0] tmo_oth_i,
  output logic        result_valid_o,
  output logic [3:0]  kind_o,
  output logic [2:0]  slot_o,
  output logic [7:0]  result_function_o,
  output logic [2:0]  exc_code_o,
  output logic        result_broadcast_o,
  output logic [3:0]  pending_after_o,
  output logic        last_o
);

  localparam int unsigned PoolSlots = PoolSlotsDef;
  localparam int unsigned SW = (PoolSlots > 1) ? $clog2(PoolSlots) : 1;
  localparam int unsigned CW = $clog2(PoolSlots + 1);

  // Captured input item.
  logic [1:0]  op_q;
  logic        ok_q;
  logic [7:0]  unit_q, fn_q, len_q;
  logic [31:0] now_q;

  // Pool and deque state.
  logic [PoolSlots-1:0] used_q;
  logic [SW-1:0]        next_q [PoolSlots];
  logic [7:0]           func_q [PoolSlots];
  logic                 bc_q   [PoolSlots];
  logic                 poi_q  [PoolSlots];
  logic [31:0]          dl_q   [PoolSlots];
  logic [SW-1:0]        head_q, tail_q;
  logic [CW-1:0]        cnt_q;

  // Result register.
  logic        rv_q, rlast_q, rbc_q;
  logic [3:0]  rkind_q, rpend_q;
  logic [2:0]  rslot_q, rexc_q;
  logic [7:0]  rfn_q;

  // Lowest free slot search.
  logic          free_found;
  logic [SW-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = PoolSlots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  // Frame classification.
  logic          bc, foreign, oversize, hp, capfull;
  logic [CW-1:0] cap;
  logic [31:0]   tsel, tmo, deadline;
  always_comb begin
    bc       = (unit_q == 8'd0);
    foreign  = !bc && (unit_q != own_unit_i);
    oversize = ({1'b0, len_q} + 9'd1) > 9'(PduLimit);
    hp       = (fn_q == FN_WRITE_SINGLE) || (fn_q == FN_WRITE_MULTI);
    if (queue_limit_i == 4'd0 || 32'(queue_limit_i) > 32'(PoolSlots)) cap = CW'(PoolSlots);
    else cap = CW'(queue_limit_i);
    capfull = !hp && !bc && (cnt_q >= cap);
    case (fn_q)
      FN_READ_HOLDING: tsel = tmo_rh_i;
      FN_WRITE_SINGLE: tsel = tmo_ws_i;
      FN_WRITE_MULTI:  tsel = tmo_wm_i;
      default:         tsel = tmo_oth_i;
    endcase
    tmo = (tsel == 32'd0) ? 32'(DefaultTimeout) : tsel;
    if (op_q == OP_POISON) deadline = now_q + 32'(PoisonTimeout);
    else deadline = now_q + tmo;
  end

  // Status.
  logic [SW-1:0] hd;
  assign hd = head_q;
  assign sts_o.is_tick     = (op_q == OP_TICK);
  assign sts_o.no_op       = (op_q == OP_NONE);
  assign sts_o.empty_now   = (cnt_q == '0);
  assign sts_o.expired     = (now_q >= dl_q[hd]);
  assign sts_o.head_poison = poi_q[hd];
  assign sts_o.single_left = (cnt_q == CW'(1));

  // Admission decision.
  logic        do_enq, enq_head;
  logic [3:0]  a_kind;
  logic [2:0]  a_exc;
  logic [7:0]  a_fn;
  logic        a_bc;
  always_comb begin
    do_enq = 1'b0; enq_head = 1'b0;
    a_kind = K_ACCEPT; a_exc = EXC_NONE; a_fn = fn_q; a_bc = 1'b0;
    if (op_q == OP_POISON) begin
      a_fn = 8'd0;
      enq_head = 1'b1;
      if (free_found) do_enq = 1'b1;
      else a_kind = K_REJ_SIL;
    end else if (!ok_q) begin
      a_kind = K_FRAME_ERR; a_fn = 8'd0;
    end else if (foreign) begin
      a_kind = K_IGNORED;
    end else if (oversize) begin
      a_kind = bc ? K_REJ_SIL : K_REJ_EXC; a_exc = EXC_ILLEGAL; a_bc = bc;
    end else if (capfull) begin
      a_kind = K_REJ_EXC; a_exc = EXC_FAIL;
    end else if (!free_found) begin
      a_kind = bc ? K_REJ_SIL : K_REJ_EXC; a_exc = EXC_FAIL; a_bc = bc;
    end else begin
      do_enq = 1'b1; enq_head = hp; a_bc = bc;
    end
  end

  logic [SW-1:0] pop_next;
  assign pop_next = next_q[hd];

  // Result fields for a popped head.
  logic [3:0] p_kind;
  logic [2:0] p_exc;
  always_comb begin
    if (cmd_i.drain) begin
      p_kind = bc_q[hd] ? K_CANCEL_SIL : K_CANCEL_EXC;
      p_exc  = bc_q[hd] ? EXC_NONE : EXC_FAIL;
    end else if (sts_o.expired) begin
      p_kind = bc_q[hd] ? K_TMO_SIL : K_TMO_EXC;
      p_exc  = bc_q[hd] ? EXC_NONE : EXC_FAIL;
    end else begin
      p_kind = K_DISPATCH;
      p_exc  = EXC_NONE;
    end
  end

  // Control registers of the pool and deque.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0; head_q <= '0; tail_q <= '0; cnt_q <= '0; rv_q <= 1'b0;
    end else begin
      rv_q <= cmd_i.admit || cmd_i.pop;
      if (cmd_i.admit && do_enq) begin
        used_q[free_slot] <= 1'b1;
        cnt_q <= cnt_q + CW'(1);
        if (enq_head) begin
          if (cnt_q == '0) tail_q <= free_slot;
          head_q <= free_slot;
        end else begin
          if (cnt_q == '0) head_q <= free_slot;
          tail_q <= free_slot;
        end
      end else if (cmd_i.pop) begin
        used_q[hd] <= 1'b0;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q != CW'(1)) head_q <= pop_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= opcode_i; ok_q <= frame_ok_i; unit_q <= frame_unit_i;
      fn_q <= frame_function_i; len_q <= payload_length_i; now_q <= now_ms_i;
    end
    if (cmd_i.admit && do_enq) begin
      func_q[free_slot] <= a_fn;
      bc_q[free_slot]   <= a_bc;
      poi_q[free_slot]  <= (op_q == OP_POISON);
      dl_q[free_slot]   <= deadline;
      next_q[free_slot] <= (enq_head && cnt_q != '0) ? head_q : '0;
      if (!enq_head && cnt_q != '0) next_q[tail_q] <= free_slot;
    end
    if (cmd_i.admit) begin
      rkind_q <= a_kind; rexc_q <= a_exc; rfn_q <= a_fn; rbc_q <= a_bc;
      rslot_q <= (do_enq) ? 3'(free_slot) : 3'd0;
      rpend_q <= 4'(do_enq ? cnt_q + CW'(1) : cnt_q);
      rlast_q <= cmd_i.final_r;
    end else if (cmd_i.pop) begin
      rkind_q <= p_kind; rexc_q <= p_exc; rfn_q <= func_q[hd];
      rbc_q   <= bc_q[hd]; rslot_q <= 3'(hd);
      rpend_q <= 4'(cnt_q - CW'(1));
      rlast_q <= cmd_i.final_r;
    end
  end

  assign result_valid_o     = rv_q;
  assign kind_o             = rkind_q;
  assign slot_o             = rslot_q;
  assign result_function_o  = rfn_q;
  assign exc_code_o         = rexc_q;
  assign result_broadcast_o = rbc_q;
  assign pending_after_o    = rpend_q;
  assign last_o             = rlast_q;

endmodule

>>> rtl/request_admission_priority_queue_core.sv
// Top level of the request admission queue with configuration registers.
// A frame or poison item holds busy over ST_EVAL and ST_DONE; its one result shows in ST_DONE.
// A tick holds busy over ST_EVAL, ST_CHECK, any ST_DRAIN and ST_DONE; the deque walk expires,
// dispatches or cancels one entry per cycle until nothing is left to dispatch.
// Results appear one per cycle with result_valid_o and cannot be stalled.
// Reset empties the pool and deque and loads register defaults.
module request_admission_priority_queue_core
  import rapq_pkg::*;
#(
  parameter int unsigned PduLimit       = PduLimitDef,
  parameter int unsigned DefaultTimeout = DefaultTimeoutDef,
  parameter int unsigned PoisonTimeout  = PoisonTimeoutDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic        frame_ok_i,
  input  logic [7:0]  frame_unit_i,
  input  logic [7:0]  frame_function_i,
  input  logic [7:0]  payload_length_i,
  input  logic [31:0] now_ms_i,
  output logic        result_valid_o,
  output logic [3:0]  kind_o,
  output logic [2:0]  slot_o,
  output logic [7:0]  result_function_o,
  output logic [2:0]  exc_code_o,
  output logic        result_broadcast_o,
  output logic [3:0]  pending_after_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  own_unit_q;
  logic [3:0]  qlimit_q;
  logic [31:0] tmo_rh_q, tmo_ws_q, tmo_wm_q, tmo_oth_q;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_unit_q <= 8'd1; qlimit_q <= 4'd8;
      tmo_rh_q <= '0; tmo_ws_q <= '0; tmo_wm_q <= '0; tmo_oth_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_OWN_UNIT: own_unit_q <= pwdata[7:0];
        REG_QLIMIT:   qlimit_q   <= pwdata[3:0];
        REG_TMO_RH:   tmo_rh_q   <= pwdata;
        REG_TMO_WS:   tmo_ws_q   <= pwdata;
        REG_TMO_WM:   tmo_wm_q   <= pwdata;
        REG_TMO_OTH:  tmo_oth_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_idx)
      REG_OWN_UNIT: prdata = {24'd0, own_unit_q};
      REG_QLIMIT:   prdata = {28'd0, qlimit_q};
      REG_TMO_RH:   prdata = tmo_rh_q;
      REG_TMO_WS:   prdata = tmo_ws_q;
      REG_TMO_WM:   prdata = tmo_wm_q;
      REG_TMO_OTH:  prdata = tmo_oth_q;
      default:      prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;

  rapq_ctrl u_ctrl (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start), .sts_i (sts),
    .busy_o (busy), .cmd_o (cmd)
  );

  rapq_dp #(
    .PduLimit (PduLimit),
    .DefaultTimeout (DefaultTimeout), .PoisonTimeout (PoisonTimeout)
  ) u_dp (
    .clk_i (clk_i), .rst_ni (rst_ni), .cmd_i (cmd),
    .sts_o (sts),
    .opcode_i (opcode_i), .frame_ok_i (frame_ok_i), .frame_unit_i (frame_unit_i),
    .frame_function_i (frame_function_i), .payload_length_i (payload_length_i),
    .now_ms_i (now_ms_i), .own_unit_i (own_unit_q), .queue_limit_i (qlimit_q),
    .tmo_rh_i (tmo_rh_q), .tmo_ws_i (tmo_ws_q), .tmo_wm_i (tmo_wm_q),
    .tmo_oth_i (tmo_oth_q),
    .result_valid_o (result_valid_o), .kind_o (kind_o), .slot_o (slot_o),
    .result_function_o (result_function_o), .exc_code_o (exc_code_o),
    .result_broadcast_o (result_broadcast_o), .pending_after_o (pending_after_o),
    .last_o (last_o)
  );

endmodule
